FILE: sv/hamming_top_k_search_assert.svh
// Assertion helpers shared by the search block.
// Each macro expects signals named clock and reset in the scope that uses it.
`ifndef HAMMING_TOP_K_SEARCH_ASSERT_SVH
`define HAMMING_TOP_K_SEARCH_ASSERT_SVH

// Same-cycle implication.
`define HKS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define HKS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/hks_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hks_pkg
// Types and constants shared by the Hamming top-k search block.
// ----------------------------------------------------------------------------
package hks_pkg;

   localparam int MAX_ENTRIES_DEF = 4096;
   localparam int MAX_WORDS_DEF   = 8;
   localparam int MAX_TOP_DEF     = 64;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_COUNT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WORDS_PER_CODE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_COUNT      = 2'd2;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef struct packed {
      logic        func;
      logic [11:0] entry;
      logic [2:0]  word_index;
      logic [31:0] code_word;
      logic        query_done;
   } req_type;

   typedef struct packed {
      logic [11:0] entry_index;
      logic [8:0]  distance;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic vld;
      logic first;
      logic last;
   } hks_tag_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_OUT
   } hks_state_type;

endpackage

FILE: sv/hks_code_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hks_code_mem
// Code store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hks_code_mem #(
   parameter int DEPTH  = hks_pkg::MAX_ENTRIES_DEF * hks_pkg::MAX_WORDS_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [31:0]       wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [31:0]       rd_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/hks_dist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hks_dist
// Distance stage: XOR and bit count of one word per cycle, accumulated over
// the words of an entry.
// ----------------------------------------------------------------------------
module hks_dist #(
   parameter int ENTRY_W = 12,
   parameter int DIST_W  = 9
) (
   input  logic                 clock,
   input  logic                 reset,
   input  hks_pkg::hks_tag_type tag,
   input  logic [ENTRY_W-1:0]   idx,
   input  logic [31:0]          qword,
   input  logic [31:0]          mdata,
   output logic                 busy,
   output logic                 dist_vld,
   output logic [DIST_W-1:0]    hdist,
   output logic [ENTRY_W-1:0]   dist_idx
);

   hks_pkg::hks_tag_type tag_ff;
   logic [ENTRY_W-1:0]   idx_ff;
   logic [31:0]          q_ff;
   logic [DIST_W-1:0]    acc_ff;
   logic [DIST_W-1:0]    acc_in;
   logic [5:0]           pc;
   logic                 dvld_ff;
   logic [DIST_W-1:0]    dist_ff;
   logic [ENTRY_W-1:0]   didx_ff;

   always_comb begin
      pc     = 6'($countones(q_ff ^ mdata));
      acc_in = (tag_ff.first ? '0 : acc_ff) + DIST_W'(pc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff  <= '0;
         dvld_ff <= 1'b0;
      end else begin
         tag_ff  <= tag;
         dvld_ff <= tag_ff.vld && tag_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx;
      q_ff   <= qword;
      if (tag_ff.vld) begin
         acc_ff <= acc_in;
         if (tag_ff.last) begin
            dist_ff <= acc_in;
            didx_ff <= idx_ff;
         end
      end
   end

   assign busy     = tag_ff.vld || dvld_ff;
   assign dist_vld = dvld_ff;
   assign hdist    = dist_ff;
   assign dist_idx = didx_ff;

endmodule

FILE: sv/hks_topk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hks_topk
// Sorted row of best cells: parallel insertion during the scan, shift
// towards the head as results are taken.
// ----------------------------------------------------------------------------
module hks_topk #(
   parameter int MAX_TOP = hks_pkg::MAX_TOP_DEF,
   parameter int ENTRY_W = 12,
   parameter int DIST_W  = 9,
   parameter int KCNT_W  = $clog2(MAX_TOP + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [KCNT_W-1:0]  limit,
   input  logic               ins_vld,
   input  logic [DIST_W-1:0]  ins_dist,
   input  logic [ENTRY_W-1:0] ins_idx,
   input  logic               pop,
   output logic [DIST_W-1:0]  head_dist,
   output logic [ENTRY_W-1:0] head_idx,
   output logic [KCNT_W-1:0]  fill
);

   logic [DIST_W-1:0]  cd_ff [MAX_TOP];
   logic [ENTRY_W-1:0] ci_ff [MAX_TOP];
   logic [DIST_W-1:0]  prev_d [MAX_TOP];
   logic [ENTRY_W-1:0] prev_i [MAX_TOP];
   logic [DIST_W-1:0]  next_d [MAX_TOP];
   logic [ENTRY_W-1:0] next_i [MAX_TOP];
   logic [MAX_TOP-1:0] lt;
   logic [MAX_TOP-1:0] prev_lt;
   logic [MAX_TOP-1:0] ok;
   logic [KCNT_W-1:0]  count_ff;
   logic               insert;

   for (genvar i = 0; i < MAX_TOP; i++) begin : g_cell
      assign lt[i] = (KCNT_W'(i) < count_ff) && (cd_ff[i] <= ins_dist);
      assign ok[i] = (KCNT_W'(i) < limit) && !lt[i];
      if (i == 0) begin : g_head
         assign prev_lt[i] = 1'b0;
         assign prev_d[i]  = ins_dist;
         assign prev_i[i]  = ins_idx;
      end else begin : g_body
         assign prev_lt[i] = lt[i-1];
         assign prev_d[i]  = cd_ff[i-1];
         assign prev_i[i]  = ci_ff[i-1];
      end
      if (i == MAX_TOP - 1) begin : g_tail
         assign next_d[i] = cd_ff[i];
         assign next_i[i] = ci_ff[i];
      end else begin : g_mid
         assign next_d[i] = cd_ff[i+1];
         assign next_i[i] = ci_ff[i+1];
      end
   end

   assign insert = ins_vld && (|ok);

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_TOP; i++) begin
         if (insert && !lt[i]) begin
            cd_ff[i] <= prev_lt[i] || i == 0 ? ins_dist : prev_d[i];
            ci_ff[i] <= prev_lt[i] || i == 0 ? ins_idx : prev_i[i];
         end else if (pop) begin
            cd_ff[i] <= next_d[i];
            ci_ff[i] <= next_i[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || start) begin
         count_ff <= '0;
      end else if (insert && count_ff < limit) begin
         count_ff <= count_ff + 1'b1;
      end else if (pop) begin
         count_ff <= count_ff - 1'b1;
      end
   end

   assign head_dist = cd_ff[0];
   assign head_idx  = ci_ff[0];
   assign fill      = count_ff;

endmodule

FILE: sv/hamming_top_k_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamming_top_k_search
// Hamming-distance top-k nearest search over a stored code database.
// ----------------------------------------------------------------------------
// Load and query words are taken one a cycle. The query word that carries
// query_done holds the request side for the search: a scan of entry_count times
// words_per_code stored words, one a cycle through the single read port of the
// code store, then a drain of the read and distance registers; the first result
// is offered the cycle after. The nearest entries then leave one a cycle unless
// the result side stalls, ascending in distance with ties to the lower index,
// the final one marked last; the request side reopens once the last result is
// taken. A search with no result (entry_count or top_count zero) holds nothing.
// ----------------------------------------------------------------------------
module hamming_top_k_search #(
   parameter int MAX_ENTRIES = hks_pkg::MAX_ENTRIES_DEF,
   parameter int MAX_WORDS   = hks_pkg::MAX_WORDS_DEF,
   parameter int MAX_TOP     = hks_pkg::MAX_TOP_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  hks_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output hks_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [hks_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [hks_pkg::CSR_W-1:0]     csr_wdata
);

   `include "hamming_top_k_search_assert.svh"

   localparam int DEPTH   = MAX_ENTRIES * MAX_WORDS;
   localparam int ADDR_W  = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int ENTRY_W = $clog2(MAX_ENTRIES);
   localparam int NCNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int WIDX_W  = MAX_WORDS > 1 ? $clog2(MAX_WORDS) : 1;
   localparam int WCNT_W  = $clog2(MAX_WORDS + 1);
   localparam int KCNT_W  = $clog2(MAX_TOP + 1);
   localparam int DIST_W  = $clog2(32 * MAX_WORDS + 1);

   hks_pkg::hks_state_type state_ff, state_in;

   logic [12:0]        cfg_ent_ff;
   logic [3:0]         cfg_wpc_ff;
   logic [6:0]         cfg_top_ff;
   logic [NCNT_W-1:0]  n_ff, n_cur;
   logic [WCNT_W-1:0]  w_ff, w_cur;
   logic [KCNT_W-1:0]  k_ff, k_cur;
   logic [ENTRY_W-1:0] ent_ff;
   logic [WIDX_W-1:0]  wc_ff;
   logic [ADDR_W-1:0]  base_ff;
   logic [31:0]        q_ff [MAX_WORDS];

   logic               req_acc, start, last_word, last_ent, scan;
   logic               ld_we, q_we;
   logic [ADDR_W-1:0]  wr_addr;
   logic [31:0]        mdata;
   logic               busy, dist_vld;
   logic [DIST_W-1:0]  hdist, head_dist;
   logic [ENTRY_W-1:0] dist_idx, head_idx;
   logic [KCNT_W-1:0]  fill;
   logic               pop;
   logic [31:0]        top_sat;
   hks_pkg::hks_tag_type tag;

   assign req_acc = req_valid && !req_stall;
   assign start   = req_acc && req_data.func == hks_pkg::FUNC_QUERY && req_data.query_done;
   assign ld_we   = req_acc && req_data.func == hks_pkg::FUNC_LOAD
                    && 32'(req_data.entry) < 32'(MAX_ENTRIES)
                    && 32'(req_data.word_index) < 32'(MAX_WORDS);
   assign q_we    = req_acc && req_data.func == hks_pkg::FUNC_QUERY
                    && 32'(req_data.word_index) < 32'(MAX_WORDS);
   assign wr_addr = ADDR_W'(32'(req_data.entry) * 32'(MAX_WORDS) + 32'(req_data.word_index));

   // clamp configuration at search start
   always_comb begin
      n_cur   = 32'(cfg_ent_ff) > 32'(MAX_ENTRIES) ? NCNT_W'(MAX_ENTRIES) : NCNT_W'(cfg_ent_ff);
      w_cur   = cfg_wpc_ff == 4'd0 ? WCNT_W'(1) :
                32'(cfg_wpc_ff) > 32'(MAX_WORDS) ? WCNT_W'(MAX_WORDS) : WCNT_W'(cfg_wpc_ff);
      top_sat = 32'(cfg_top_ff) > 32'(MAX_TOP) ? 32'(MAX_TOP) : 32'(cfg_top_ff);
      k_cur   = top_sat > 32'(n_cur) ? KCNT_W'(n_cur) : KCNT_W'(top_sat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ent_ff <= 13'd1;
         cfg_wpc_ff <= 4'd8;
         cfg_top_ff <= 7'd64;
      end else if (csr_we) begin
         case (csr_index)
            hks_pkg::CSR_ENTRY_COUNT:    cfg_ent_ff <= csr_wdata;
            hks_pkg::CSR_WORDS_PER_CODE: cfg_wpc_ff <= csr_wdata[3:0];
            hks_pkg::CSR_TOP_COUNT:      cfg_top_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (q_we) begin
         q_ff[WIDX_W'(req_data.word_index)] <= req_data.code_word;
      end
   end

   assign scan      = state_ff == hks_pkg::ST_SCAN;
   assign last_word = WCNT_W'(wc_ff) == w_ff - 1'b1;
   assign last_ent  = ent_ff == ENTRY_W'(n_ff - 1'b1);
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hks_pkg::ST_IDLE:  if (start && k_cur != '0) state_in = hks_pkg::ST_SCAN;
         hks_pkg::ST_SCAN:  if (last_word && last_ent) state_in = hks_pkg::ST_DRAIN;
         hks_pkg::ST_DRAIN: if (!busy) state_in = hks_pkg::ST_OUT;
         hks_pkg::ST_OUT:   if (pop && fill == KCNT_W'(1)) state_in = hks_pkg::ST_IDLE;
         default:           state_in = hks_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hks_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         n_ff    <= n_cur;
         w_ff    <= w_cur;
         k_ff    <= k_cur;
         ent_ff  <= '0;
         wc_ff   <= '0;
         base_ff <= '0;
      end else if (scan) begin
         if (last_word) begin
            wc_ff   <= '0;
            ent_ff  <= ent_ff + 1'b1;
            base_ff <= base_ff + ADDR_W'(MAX_WORDS);
         end else begin
            wc_ff <= wc_ff + 1'b1;
         end
      end
   end

   assign tag.vld   = scan;
   assign tag.first = wc_ff == '0;
   assign tag.last  = last_word;

   hks_code_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (ld_we),
      .wr_addr (wr_addr),
      .wr_data (req_data.code_word),
      .rd_en   (scan),
      .rd_addr (base_ff + ADDR_W'(wc_ff)),
      .rd_data (mdata)
   );

   hks_dist #(
      .ENTRY_W (ENTRY_W),
      .DIST_W  (DIST_W)
   ) u_dist (
      .clock    (clock),
      .reset    (reset),
      .tag      (tag),
      .idx      (ent_ff),
      .qword    (q_ff[wc_ff]),
      .mdata    (mdata),
      .busy     (busy),
      .dist_vld (dist_vld),
      .hdist    (hdist),
      .dist_idx (dist_idx)
   );

   hks_topk #(
      .MAX_TOP (MAX_TOP),
      .ENTRY_W (ENTRY_W),
      .DIST_W  (DIST_W),
      .KCNT_W  (KCNT_W)
   ) u_topk (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .limit     (k_ff),
      .ins_vld   (dist_vld),
      .ins_dist  (hdist),
      .ins_idx   (dist_idx),
      .pop       (pop),
      .head_dist (head_dist),
      .head_idx  (head_idx),
      .fill      (fill)
   );

   assign req_stall            = state_ff != hks_pkg::ST_IDLE;
   assign rsp_valid            = state_ff == hks_pkg::ST_OUT;
   assign rsp_data.entry_index = 12'(head_idx);
   assign rsp_data.distance    = 9'(head_dist);
   assign rsp_data.last        = fill == KCNT_W'(1);

   `HKS_ASSERT_NOW(a_ins_in_search, dist_vld,
      state_ff == hks_pkg::ST_SCAN || state_ff == hks_pkg::ST_DRAIN,
      "distance produced outside a search")
   `HKS_ASSERT_NOW(a_out_nonempty, rsp_valid, fill != '0 && fill <= k_ff,
      "result shown with empty or overfull best list")
   `HKS_ASSERT_NEXT(a_last_ends, pop && rsp_data.last, !rsp_valid && !req_stall,
      "results continue after the last beat")

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Hamming top-k search block. Database and query
// beats go in through the request channel under random bursts and gaps, and
// the result channel stalls on a pattern of its own. A predictor keeps its own
// copy of the code store, the query and the registers, and lists the nearest
// entries of every search after the first directed one for each result beat.
// ----------------------------------------------------------------------------
module tb;

   typedef struct {
      hks_pkg::req_type req;
      bit               typed;
      hks_pkg::rsp_type want;
   } dir_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   hks_pkg::req_type              req_data = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   hks_pkg::rsp_type              rsp_data;
   logic                          csr_we = 1'b0;
   logic [hks_pkg::CSR_IDX_W-1:0] csr_index = hks_pkg::CSR_ENTRY_COUNT;
   logic [hks_pkg::CSR_W-1:0]     csr_wdata = '0;

   logic [31:0]  code_mem [0:hks_pkg::MAX_ENTRIES_DEF*hks_pkg::MAX_WORDS_DEF-1];
   bit           code_seen [0:hks_pkg::MAX_ENTRIES_DEF*hks_pkg::MAX_WORDS_DEF-1];
   logic [31:0]  query_mem [0:hks_pkg::MAX_WORDS_DEF-1];
   bit           query_seen [0:hks_pkg::MAX_WORDS_DEF-1];
   logic [12:0]  entry_count_reg = 13'd1;
   logic [3:0]   words_reg = 4'd8;
   logic [6:0]   top_reg = 7'd64;

   hks_pkg::rsp_type nearest_q [$];
   dir_row_type      dir_rows [$];
   int           errors = 0;
   int           searches = 0;
   int           beats_checked = 0;
   int           burst_left = 0;
   int           scan_cycles = 0;
   int           stall_mode = 0;
   int           cyc = 0;

   hamming_top_k_search DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   initial begin
      #20ms;
      $display("hamming_top_k_search verification failed");
      $finish;
   end

   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (cyc % 300 == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= (cyc % 16) < 10;
      endcase
   end

   always @(negedge clock) begin
      hks_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (nearest_q.size() == 0) begin
            $display("%0t unexpected beat: got %p", $realtime, rsp_data);
            errors++;
         end else begin
            want = nearest_q.pop_front();
            beats_checked++;
            if (rsp_data.entry_index !== want.entry_index ||
                rsp_data.distance !== want.distance || rsp_data.last !== want.last) begin
               $display("%0t mismatch: expected %p, actual %p", $realtime, want, rsp_data);
               errors++;
            end
         end
      end
   end

   function automatic int eff_entries();
      return (entry_count_reg > hks_pkg::MAX_ENTRIES_DEF) ? hks_pkg::MAX_ENTRIES_DEF
                                                          : int'(entry_count_reg);
   endfunction

   function automatic int eff_words();
      if (words_reg == 0) return 1;
      return (words_reg > hks_pkg::MAX_WORDS_DEF) ? hks_pkg::MAX_WORDS_DEF : int'(words_reg);
   endfunction

   // Build the sorted nearest list of one search and queue its beats when asked to.
   function automatic void predict_nearest(bit push);
      int               n, w, k, fill, pos, j, hd;
      logic [8:0]       bd [0:hks_pkg::MAX_TOP_DEF-1];
      logic [11:0]      bi [0:hks_pkg::MAX_TOP_DEF-1];
      hks_pkg::rsp_type r;
      n = eff_entries();
      w = eff_words();
      k = (top_reg > hks_pkg::MAX_TOP_DEF) ? hks_pkg::MAX_TOP_DEF : int'(top_reg);
      if (k > n) k = n;
      fill = 0;
      scan_cycles = n * w;
      if (k == 0) return;
      for (int i = 0; i < n; i++) begin
         hd = 0;
         for (int x = 0; x < w; x++)
            hd += $countones(query_mem[x] ^ code_mem[i*hks_pkg::MAX_WORDS_DEF + x]);
         if (fill >= k && hd >= bd[k-1]) continue;
         pos = 0;
         while (pos < fill && bd[pos] <= hd) pos++;
         j = (fill < k) ? fill : k - 1;
         while (j > pos) begin
            bd[j] = bd[j-1];
            bi[j] = bi[j-1];
            j--;
         end
         bd[pos] = hd[8:0];
         bi[pos] = i[11:0];
         if (fill < k) fill++;
      end
      if (!push) return;
      for (int i = 0; i < fill; i++) begin
         r.entry_index = bi[i];
         r.distance    = bd[i];
         r.last        = (i + 1 == fill);
         nearest_q = {nearest_q, r};
      end
   endfunction

   function automatic void absorb(hks_pkg::req_type r, bit push);
      if (r.func == hks_pkg::FUNC_LOAD) begin
         code_mem[r.entry*hks_pkg::MAX_WORDS_DEF + r.word_index]  = r.code_word;
         code_seen[r.entry*hks_pkg::MAX_WORDS_DEF + r.word_index] = 1'b1;
      end else begin
         query_mem[r.word_index]  = r.code_word;
         query_seen[r.word_index] = 1'b1;
         if (r.query_done) begin
            searches++;
            predict_nearest(push);
         end
      end
   endfunction

   function automatic hks_pkg::req_type mk(logic f, int e, int wi, logic [31:0] cw, logic d);
      hks_pkg::req_type r;
      r.func = f; r.entry = e[11:0]; r.word_index = wi[2:0];
      r.code_word = cw; r.query_done = d;
      return r;
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h1 << $urandom_range(0, 31);
         3: return $urandom & 32'h0000_000F;
         default: return $urandom;
      endcase
   endfunction

   task automatic send(hks_pkg::req_type r, bit push);
      bit open;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= r;
      forever begin
         @(negedge clock);
         open = !req_stall;
         @(posedge clock);
         if (open) break;
      end
      absorb(r, push);
   endtask

   // Hold until every result beat is in, then let a silent search finish.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (nearest_q.size() != 0) @(posedge clock);
      repeat (scan_cycles + 40) @(posedge clock);
   endtask

   task automatic csr_write(logic [hks_pkg::CSR_IDX_W-1:0] idx, int val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[hks_pkg::CSR_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == hks_pkg::CSR_ENTRY_COUNT) entry_count_reg = val[12:0];
      else if (idx == hks_pkg::CSR_WORDS_PER_CODE) words_reg = val[3:0];
      else top_reg = val[6:0];
      @(posedge clock);
   endtask

   task automatic run_phase(int ec, int wpc, int tc, int n_search);
      int n, w;
      wait_idle();
      csr_write(hks_pkg::CSR_ENTRY_COUNT, ec);
      csr_write(hks_pkg::CSR_WORDS_PER_CODE, wpc);
      csr_write(hks_pkg::CSR_TOP_COUNT, tc);
      n = eff_entries();
      w = eff_words();
      for (int e = 0; e < n; e++)
         for (int x = 0; x < w; x++)
            if (!code_seen[e*hks_pkg::MAX_WORDS_DEF + x])
               send(mk(hks_pkg::FUNC_LOAD, e, x, pick_word(), $urandom_range(0, 1)), 1'b1);
      for (int x = 0; x < w; x++)
         if (!query_seen[x]) send(mk(hks_pkg::FUNC_QUERY, 0, x, pick_word(), 1'b0), 1'b1);
      for (int s = 0; s < n_search; s++) begin
         repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 4) == 0)
               send(mk(hks_pkg::FUNC_LOAD, $urandom_range(0, 4095), $urandom_range(0, 7),
                       $urandom, $urandom_range(0, 1)), 1'b1);
            else
               send(mk(hks_pkg::FUNC_LOAD, $urandom_range(0, n - 1), $urandom_range(0, w - 1),
                       pick_word(), 1'b0), 1'b1);
         end
         repeat ($urandom_range(0, 3))
            send(mk(hks_pkg::FUNC_QUERY, $urandom, $urandom_range(0, 7), pick_word(), 1'b0),
                 1'b1);
         send(mk(hks_pkg::FUNC_QUERY, $urandom, $urandom_range(0, 7), pick_word(), 1'b1), 1'b1);
      end
   endtask

   initial begin
      dir_row_type row;
      for (int i = 0; i < hks_pkg::MAX_ENTRIES_DEF*hks_pkg::MAX_WORDS_DEF; i++) begin
         code_mem[i] = '0;
         code_seen[i] = 1'b0;
      end
      for (int i = 0; i < hks_pkg::MAX_WORDS_DEF; i++) begin
         query_mem[i] = '0;
         query_seen[i] = 1'b0;
      end
      // all ones against all zeros over eight words after reset
      for (int i = 0; i < 8; i++) begin
         row.req = mk(hks_pkg::FUNC_LOAD, 0, i, 32'hFFFF_FFFF, 1'b0);
         row.typed = 1'b0;
         dir_rows = {dir_rows, row};
      end
      for (int i = 0; i < 8; i++) begin
         row.req = mk(hks_pkg::FUNC_QUERY, 4095, i, 32'h0, i == 7);
         row.typed = (i == 7);
         row.want = '{entry_index: 12'd0, distance: 9'd256, last: 1'b1};
         dir_rows = {dir_rows, row};
      end
      row.typed = 1'b0;
      row.req = mk(hks_pkg::FUNC_LOAD, 0, 3, 32'h0, 1'b1);
      dir_rows = {dir_rows, row};
      row.req = mk(hks_pkg::FUNC_LOAD, 4095, 7, 32'hA5A5_5A5A, 1'b0);
      dir_rows = {dir_rows, row};
      row.req = mk(hks_pkg::FUNC_QUERY, 0, 7, 32'h0000_FFFF, 1'b1);
      dir_rows = {dir_rows, row};
      row.req = mk(hks_pkg::FUNC_QUERY, 0, 0, 32'hFFFF_FFFF, 1'b1);
      dir_rows = {dir_rows, row};

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         send(dir_rows[i].req, !dir_rows[i].typed);
         if (dir_rows[i].typed) nearest_q = {nearest_q, dir_rows[i].want};
      end

      run_phase(4, 3, 2, 2);
      run_phase(0, 2, 5, 1);
      run_phase(6, 0, 127, 2);
      run_phase(2, 15, 3, 1);
      run_phase(3, 1, 0, 1);
      run_phase(3, 1, 64, 2);
      run_phase(1, 8, 1, 2);
      repeat (2)
         run_phase($urandom_range(1, 8), $urandom_range(1, 4), $urandom_range(0, 70), 2);

      wait_idle();
      repeat (50) @(posedge clock);
      $display("Ran %0d searches over loads, queries and register extremes;", searches);
      $display("checked %0d result beats under random bursts and stalls.", beats_checked);
      if (errors == 0 && nearest_q.size() == 0) begin
         $display("hamming_top_k_search verification clean");
      end else begin
         $display("hamming_top_k_search verification failed");
      end
      $finish;
   end

endmodule

FILE: hamming_top_k_search.f
+incdir+sv
sv/hks_pkg.sv
sv/hks_code_mem.sv
sv/hks_dist.sv
sv/hks_topk.sv
sv/hamming_top_k_search.sv
bench/tb.sv
